// File: hw/rtl/double_ended_queue_with_index_defines.svh
// assertion macros used by the double-ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_WITH_INDEX_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_INDEX_DEFINES_SVH

`ifndef SYNTH
// property holds at every edge outside reset
`define DQI_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("dqi assertion failed");
// consequent holds in the cycle after the antecedent
`define DQI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("dqi assertion failed");
`else
`define DQI_ASSERT(lbl, clk, rstn, prop)
`define DQI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/dqi_pkg.sv
// types and constants of the double-ended queue
`timescale 1ns / 1ps

package dqi_pkg;

	localparam int DEPTH   = 256;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = ADDR_W + 1;
	localparam int VALUE_W = 32;
	localparam int OP_W    = 3;
	localparam int POS_W   = 8;
	localparam int ST_W    = 2;
	localparam int IN_W    = OP_W + VALUE_W + POS_W;
	localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W   = VALUE_W + ST_W + CNT_W + 1;
	localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_REVERSE    = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// what an item carries from the store access to the output register
	typedef struct packed {
		logic             use_rdata;
		status_t          status;
		logic [CNT_W-1:0] fill_count;
	} s1_info_t;

endpackage

// File: hw/rtl/double_ended_queue_with_index.sv
// top level of the double-ended queue with indexed read
//
// One request channel (s_axis) and one result channel (m_axis), both plain
// valid/ready streams. Each request item gives exactly one result item.
// Request tdata holds opcode, push_value and position; result tdata holds
// read_value, status, fill_count and is_empty.
// The entries sit in one 256 x 32 synchronous memory with a registered read.
// Head pointer, count and orientation are updated at the edge that accepts a
// request, and the store is written (push) or read (pop, read) at that edge.
// The read data is registered in the access stage and latched with the status
// into the output register once that register is free, which drives m_tvalid.
// A new request is taken every cycle as long as the result path moves; the
// single memory port is used once per item, so the rate is one item a cycle.
// When the receiver stalls, the output register holds its item, the item
// after it waits in the access stage with its read data held, and s_tready
// drops until the output register is taken.
// Reset clears head, count, orientation and all valid flags; the queue is
// empty and ready right after reset, the store contents are not cleared.
`timescale 1ns / 1ps
`include "double_ended_queue_with_index_defines.svh"

module double_ended_queue_with_index (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// opcode [2:0], push_value [34:3], position [42:35], zeros above
	input  logic [dqi_pkg::IN_TW-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// read_value [31:0], status [33:32], fill_count [42:34], is_empty [43], zeros above
	output logic [dqi_pkg::OUT_TW-1:0] m_tdata
);

	// request fields
	logic [dqi_pkg::OP_W-1:0]    opcode;
	logic [dqi_pkg::VALUE_W-1:0] push_value;
	logic [dqi_pkg::POS_W-1:0]   position;
	dqi_pkg::op_t                op;

	assign opcode     = s_tdata[dqi_pkg::OP_W-1:0];
	assign push_value = s_tdata[dqi_pkg::OP_W +: dqi_pkg::VALUE_W];
	assign position   = s_tdata[dqi_pkg::OP_W + dqi_pkg::VALUE_W +: dqi_pkg::POS_W];
	assign op         = dqi_pkg::op_t'(opcode);

	// queue state
	logic [dqi_pkg::ADDR_W-1:0] head_q;
	logic [dqi_pkg::CNT_W-1:0]  count_q;
	logic                       rev_q;

	// pipeline control
	logic              s1_valid_s1;
	dqi_pkg::s1_info_t s1_info_s1;
	logic              out_valid_q;
	logic [dqi_pkg::VALUE_W-1:0] out_value_q;
	dqi_pkg::status_t  out_status_q;
	logic [dqi_pkg::CNT_W-1:0]   out_count_q;

	logic accept;
	logic s1_adv;

	assign s1_adv   = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;

	// decode of one request against the current state
	logic                       full;
	logic                       empty;
	logic [dqi_pkg::ADDR_W-1:0] cnt_lo;
	logic [dqi_pkg::ADDR_W-1:0] last_off;
	logic [dqi_pkg::ADDR_W-1:0] pos_off;
	logic                       pos_bad;
	logic [dqi_pkg::ADDR_W-1:0] head_d;
	logic [dqi_pkg::CNT_W-1:0]  count_d;
	logic                       rev_d;
	logic [dqi_pkg::ADDR_W-1:0] mem_addr;
	logic                       mem_we;
	logic                       mem_re;
	dqi_pkg::status_t           status_d;

	assign full     = (count_q >= dqi_pkg::CNT_W'(dqi_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign cnt_lo   = count_q[dqi_pkg::ADDR_W-1:0];
	assign last_off = cnt_lo - dqi_pkg::ADDR_W'(1);
	assign pos_off  = dqi_pkg::ADDR_W'(position);
	assign pos_bad  = (dqi_pkg::CNT_W'(position) >= count_q);

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		rev_d    = rev_q;
		mem_addr = head_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		status_d = dqi_pkg::ST_OK;
		unique case (op)
			dqi_pkg::OP_PUSH_BACK, dqi_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = dqi_pkg::ST_FULL;
				end else begin
					mem_we  = 1'b1;
					count_d = count_q + dqi_pkg::CNT_W'(1);
					// low end when pushing front in normal or back in reversed order
					if ((op == dqi_pkg::OP_PUSH_FRONT) != rev_q) begin
						head_d   = head_q - dqi_pkg::ADDR_W'(1);
						mem_addr = head_q - dqi_pkg::ADDR_W'(1);
					end else begin
						mem_addr = head_q + cnt_lo;
					end
				end
			end
			dqi_pkg::OP_POP_BACK, dqi_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_d = dqi_pkg::ST_EMPTY;
				end else begin
					mem_re  = 1'b1;
					count_d = count_q - dqi_pkg::CNT_W'(1);
					if ((op == dqi_pkg::OP_POP_FRONT) != rev_q) begin
						head_d   = head_q + dqi_pkg::ADDR_W'(1);
						mem_addr = head_q;
					end else begin
						mem_addr = head_q + last_off;
					end
				end
			end
			dqi_pkg::OP_READ: begin
				if (pos_bad) begin
					status_d = dqi_pkg::ST_RANGE;
				end else begin
					mem_re = 1'b1;
					if (rev_q) begin
						mem_addr = head_q + (last_off - pos_off);
					end else begin
						mem_addr = head_q + pos_off;
					end
				end
			end
			dqi_pkg::OP_REVERSE: begin
				if (!empty) begin
					rev_d = !rev_q;
				end
			end
			default: begin
			end
		endcase
	end

	// entry store, one access per item
	logic [dqi_pkg::VALUE_W-1:0] mem_q [dqi_pkg::DEPTH];
	logic [dqi_pkg::VALUE_W-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			mem_q[mem_addr] <= push_value;
		end
		if (accept && mem_re) begin
			rdata_s1 <= mem_q[mem_addr];
		end
	end

	// queue state update at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
			rev_q   <= rev_d;
		end
	end

	// access stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_info_s1.use_rdata  <= mem_re;
			s1_info_s1.status     <= status_d;
			s1_info_s1.fill_count <= count_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_s1) begin
			out_value_q  <= s1_info_s1.use_rdata ? rdata_s1 : '0;
			out_status_q <= s1_info_s1.status;
			out_count_q  <= s1_info_s1.fill_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dqi_pkg::OUT_TW'({(out_count_q == '0), out_count_q,
		out_status_q, out_value_q});

	// checks
	`DQI_ASSERT(a_count_bound, clk, arst_n,
		count_q <= dqi_pkg::CNT_W'(dqi_pkg::DEPTH))
	`DQI_ASSERT(a_stall_blocks, clk, arst_n,
		(s1_valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
	`DQI_ASSERT_NEXT(a_pop_count, clk, arst_n,
		accept && (op == dqi_pkg::OP_POP_BACK || op == dqi_pkg::OP_POP_FRONT) && !empty,
		count_q == $past(count_q) - dqi_pkg::CNT_W'(1))
	`DQI_ASSERT_NEXT(a_rev_empty, clk, arst_n,
		empty && !(accept && (op == dqi_pkg::OP_PUSH_BACK || op == dqi_pkg::OP_PUSH_FRONT)),
		$stable(rev_q))
	`DQI_ASSERT_NEXT(a_full_no_write, clk, arst_n,
		accept && full,
		count_q == $past(count_q) || count_q == $past(count_q) - dqi_pkg::CNT_W'(1))

endmodule
